// ----- hdl/lhbp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhbp_pkg
// Shared types and constants of the local history branch predictor.
// ----------------------------------------------------------------------------
package lhbp_pkg;

  localparam int ADDR_W   = 16;
  localparam int CFG_W    = 5;
  localparam int HIST_W   = 3;
  localparam int PATTERNS = 1 << HIST_W;
  localparam int CTR_W    = 3;
  localparam int MISS_W   = 16;
  localparam int OIDX_W   = 4;
  localparam int BITCNT_W = 4;

  localparam logic [CFG_W-1:0]    CFG_RESET     = 5'd16;
  localparam logic [CTR_W-1:0]    CTR_SN        = 3'd0;
  localparam logic [CTR_W-1:0]    CTR_ST        = 3'd7;
  localparam logic [CTR_W-1:0]    CTR_TAKEN_MIN = 3'd4;
  localparam logic [MISS_W-1:0]   MISS_MAX      = 16'hFFFF;
  localparam logic [BITCNT_W-1:0] DIV_LAST_BIT  = 4'd15;

  // Input transaction
  typedef struct packed {
    logic [ADDR_W-1:0] branch_address;
    logic              actual_taken;
  } in_t;

  // Result transaction
  typedef struct packed {
    logic [OIDX_W-1:0] entry_index;
    logic              predicted_taken;
    logic              mispredicted;
    logic [MISS_W-1:0] miss_count;
  } out_t;

  // One predictor entry as held in the row memory
  typedef struct packed {
    logic [MISS_W-1:0]               miss_total;
    logic [HIST_W-1:0]               history;
    logic [PATTERNS-1:0][CTR_W-1:0]  counters;
  } row_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic clr_en;
    logic load;
    logic div_step;
    logic rd_en;
    logic upd;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic clr_last;
    logic div_last;
  } stat_t;

endpackage

// ----- hdl/lhbp_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhbp_ctrl
// Sequencer: clearing pass, idle, remainder iterations, row read, update.
// ----------------------------------------------------------------------------
module lhbp_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  lhbp_pkg::stat_t stat,
  output lhbp_pkg::cmd_t  cmd
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_UPD   = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  // Work out the next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (stat.clr_last) state_nxt = S_IDLE;
      S_IDLE:  if (start) state_nxt = S_DIV;
      S_DIV:   if (stat.div_last) state_nxt = S_READ;
      S_READ:  state_nxt = S_UPD;
      S_UPD:   state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  // Hold the state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Drive datapath commands
  always_comb begin
    cmd          = '0;
    cmd.clr_en   = (state_r == S_CLEAR);
    cmd.load     = (state_r == S_IDLE) && start;
    cmd.div_step = (state_r == S_DIV);
    cmd.rd_en    = (state_r == S_READ);
    cmd.upd      = (state_r == S_UPD);
  end

  assign busy = (state_r != S_IDLE);

endmodule

// ----- hdl/lhbp_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhbp_dpath
// Datapath: entry count register, bit-serial remainder, row memory and update.
// ----------------------------------------------------------------------------
module lhbp_dpath #(
  parameter int ENTRIES = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [lhbp_pkg::CFG_W-1:0]      cfg_wdata,
  input  lhbp_pkg::in_t                   in_item,
  input  lhbp_pkg::cmd_t                  cmd,
  output lhbp_pkg::stat_t                 stat,
  output logic                            out_strobe,
  output lhbp_pkg::out_t                  out_item
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IDX_W-1:0] CLR_LAST = IDX_W'(ENTRIES - 1);

  // Entry count register and clamped divisor
  logic [lhbp_pkg::CFG_W-1:0] cfg_r;
  logic [lhbp_pkg::CFG_W-1:0] div_r;
  logic [lhbp_pkg::CFG_W-1:0] div_nxt;

  // Remainder iteration
  logic [lhbp_pkg::ADDR_W-1:0]   addr_r;
  logic                          taken_r;
  logic [lhbp_pkg::CFG_W-1:0]    rem_r;
  logic [lhbp_pkg::CFG_W-1:0]    rem_nxt;
  logic [lhbp_pkg::CFG_W:0]      rem_shift;
  logic [lhbp_pkg::BITCNT_W-1:0] bit_cnt_r;

  // Row memory
  lhbp_pkg::row_t row_mem [ENTRIES];
  lhbp_pkg::row_t rd_row_r;
  lhbp_pkg::row_t wr_row;
  logic [IDX_W-1:0] wr_addr;
  logic [IDX_W-1:0] entry_idx;
  logic [IDX_W-1:0] clr_cnt_r;

  // Update logic
  logic [lhbp_pkg::CTR_W-1:0]  ctr;
  logic [lhbp_pkg::CTR_W-1:0]  ctr_nxt;
  logic                        pred;
  logic                        miss;
  logic [lhbp_pkg::MISS_W-1:0] miss_nxt;

  logic          out_strobe_r;
  lhbp_pkg::out_t out_item_r;

  // Store the entry count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= lhbp_pkg::CFG_RESET;
    end else if (cfg_we) begin
      cfg_r <= cfg_wdata;
    end
  end

  // Clamp the entry count to one and to the table depth
  always_comb begin
    if (cfg_r == '0) begin
      div_nxt = lhbp_pkg::CFG_W'(1);
    end else if (32'(cfg_r) > ENTRIES) begin
      div_nxt = lhbp_pkg::CFG_W'(ENTRIES);
    end else begin
      div_nxt = cfg_r;
    end
  end

  // One restoring remainder step per cycle, address MSB first
  always_comb begin
    rem_shift = {rem_r, addr_r[lhbp_pkg::ADDR_W-1]};
    if (rem_shift >= {1'b0, div_r}) begin
      rem_nxt = lhbp_pkg::CFG_W'(rem_shift - {1'b0, div_r});
    end else begin
      rem_nxt = rem_shift[lhbp_pkg::CFG_W-1:0];
    end
  end

  // Latch the transaction and advance the remainder
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      addr_r    <= in_item.branch_address;
      taken_r   <= in_item.actual_taken;
      div_r     <= div_nxt;
      rem_r     <= '0;
      bit_cnt_r <= '0;
    end else if (cmd.div_step) begin
      addr_r    <= addr_r << 1;
      rem_r     <= rem_nxt;
      bit_cnt_r <= bit_cnt_r + 1'b1;
    end
  end

  assign entry_idx     = IDX_W'(rem_r);
  assign stat.div_last = (bit_cnt_r == lhbp_pkg::DIV_LAST_BIT);
  assign stat.clr_last = (clr_cnt_r == CLR_LAST);

  // Advance the clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_en) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  // Predict from the row and build its updated form
  always_comb begin
    ctr  = rd_row_r.counters[rd_row_r.history];
    pred = (ctr >= lhbp_pkg::CTR_TAKEN_MIN);
    miss = (pred != taken_r);
    if (taken_r) begin
      ctr_nxt = (ctr == lhbp_pkg::CTR_ST) ? ctr : ctr + 1'b1;
    end else begin
      ctr_nxt = (ctr == lhbp_pkg::CTR_SN) ? ctr : ctr - 1'b1;
    end
    if (miss && (rd_row_r.miss_total != lhbp_pkg::MISS_MAX)) begin
      miss_nxt = rd_row_r.miss_total + 1'b1;
    end else begin
      miss_nxt = rd_row_r.miss_total;
    end
    if (cmd.clr_en) begin
      wr_row  = '0;
      wr_addr = clr_cnt_r;
    end else begin
      wr_row                             = rd_row_r;
      wr_row.counters[rd_row_r.history]  = ctr_nxt;
      wr_row.history                     = {rd_row_r.history[lhbp_pkg::HIST_W-2:0], taken_r};
      wr_row.miss_total                  = miss_nxt;
      wr_addr                            = entry_idx;
    end
  end

  // Row memory: one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.clr_en || cmd.upd) begin
      row_mem[wr_addr] <= wr_row;
    end
    if (cmd.rd_en) begin
      rd_row_r <= row_mem[entry_idx];
    end
  end

  // Present the result for one cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= cmd.upd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      out_item_r.entry_index     <= rem_r[lhbp_pkg::OIDX_W-1:0];
      out_item_r.predicted_taken <= pred;
      out_item_r.mispredicted    <= miss;
      out_item_r.miss_count      <= miss_nxt;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule

// ----- hdl/local_history_branch_predictor_core.sv -----
`timescale 1ns / 1ps
// After the start edge the core runs 16 remainder steps of the 16-bit address
// (one bit a cycle), one row read and one update; the result strobe is registered.
// Start is taken only in idle; busy is high from the first step to the update.
// Reset: a clearing pass zeroes the row memory, busy high.
// The receiver cannot stall: each result strobe is high for exactly one cycle.
// ----------------------------------------------------------------------------
// local_history_branch_predictor_core
// Two-level local history predictor with 3-bit counters and miss totals.
// ----------------------------------------------------------------------------
module local_history_branch_predictor_core #(
  parameter int ENTRIES = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [lhbp_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic                        start,
  output logic                        busy,
  input  lhbp_pkg::in_t               in_item,
  output logic                        out_strobe,
  output lhbp_pkg::out_t              out_item
);

  lhbp_pkg::cmd_t  cmd;
  lhbp_pkg::stat_t stat;

  // Sequencer
  lhbp_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // Datapath
  lhbp_dpath #(
    .ENTRIES (ENTRIES)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_item    (in_item),
    .cmd        (cmd),
    .stat       (stat),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule
